[rtl/core/dpf_pkg.sv]
// ----------------------------------------------------------------------------
// dpf_pkg
// Types and constants shared by the packet framer core and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpf_pkg;

  localparam int HistDepth = 12;
  localparam int WinLen    = 8;
  localparam int WinBase   = HistDepth - WinLen;

  typedef logic [15:0] word_t;
  typedef word_t [HistDepth-1:0] hist_t;
  typedef word_t [WinLen-1:0] burst_t;
  typedef logic [4:0] count_t;
  typedef logic [3:0] nib_t;
  typedef logic [3:0] rem_t;

  // Framer modes.
  localparam logic [1:0] MODE_HUNT  = 2'd0;
  localparam logic [1:0] MODE_KIND0 = 2'd1;
  localparam logic [1:0] MODE_KIND1 = 2'd2;

  // Word count after a start burst, saturation point, and trailer minimum.
  localparam count_t CountStart  = count_t'(WinLen);
  localparam count_t CountSat    = 5'd20;
  localparam count_t EndMinCount = 5'd19;
  localparam rem_t   BurstRem    = rem_t'(WinLen);

  // Marker words and marker nibbles.
  localparam word_t WORD_8000 = 16'h8000;
  localparam word_t WORD_0001 = 16'h0001;
  localparam word_t WORD_FFFF = 16'hFFFF;
  localparam nib_t  NIB_9     = 4'h9;
  localparam nib_t  NIB_A     = 4'hA;
  localparam nib_t  NIB_E     = 4'hE;
  localparam nib_t  NIB_F     = 4'hF;

  // Header and trailer matches on the updated history.
  typedef struct packed {
    logic start0;
    logic start1;
    logic end0;
    logic end1;
  } match_t;

  // Request to load results into the output queue.
  typedef struct packed {
    logic valid;
    logic burst;
    logic last;
    logic kind;
  } load_t;

endpackage

`default_nettype wire

[rtl/core/daq_packet_framer_core.sv]
// ----------------------------------------------------------------------------
// daq_packet_framer_core
// Cuts a raw 16-bit word stream into packets of two header kinds and marks
// first, last and kind on every forwarded word.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   input   | in_valid / in_stall   | data_word
//   output  | out_valid / out_stall | out_word, packet_first, packet_last,
//           |                       | packet_kind, burst_last
//
// Inside a packet one input word yields one output word, and a new word is
// taken every cycle as long as the output side keeps up.
// A header match yields a burst of eight words; in_stall is high while the
// output queue drains it, until its final word is being taken.
// Hunting words that match no header produce no transaction at all.
// Reset clears the history to zeros, selects hunting and empties the queue.
// in_stall follows out_stall combinationally through the queue's drain logic.
`default_nettype none

module daq_packet_framer_core import dpf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t data_word,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t out_word,
  output logic  packet_first,
  output logic  packet_last,
  output logic  packet_kind,
  output logic  burst_last
);

  // The history holds the last twelve words; the newest sits at the top
  // index. The hunting window is the upper eight entries.
  hist_t      hist;
  hist_t      hist_next;
  hist_t      hist_shift;
  logic [1:0] mode;
  logic [1:0] mode_next;
  count_t     count;
  count_t     count_next;

  match_t match;
  load_t  load;
  logic   free;
  logic   in_acc;
  logic   in_pkt;
  logic   kind_cur;
  logic   end_hit;
  logic   start_hit;

  assign in_stall   = !free;
  assign in_acc     = in_valid && free;
  assign hist_shift = {data_word, hist[HistDepth-1:1]};

  dpf_match u_match (
    .hist  (hist_shift),
    .count (count),
    .match (match)
  );

  // The unused mode code is treated as hunting.
  assign in_pkt    = (mode == MODE_KIND0) || (mode == MODE_KIND1);
  assign kind_cur  = (mode == MODE_KIND1);
  assign end_hit   = kind_cur ? match.end1 : match.end0;
  assign start_hit = match.start0 || match.start1;

  always_comb begin
    load.valid = in_acc && (in_pkt || start_hit);
    load.burst = !in_pkt;
    load.last  = in_pkt && end_hit;
    load.kind  = in_pkt ? kind_cur : !match.start0;
  end

  always_comb begin
    hist_next  = hist;
    mode_next  = mode;
    count_next = count;
    if (in_acc) begin
      if (in_pkt) begin
        if (end_hit) begin
          // The trailer closes the packet and hunting restarts on a clean
          // window.
          hist_next  = '0;
          mode_next  = MODE_HUNT;
          count_next = '0;
        end else begin
          hist_next = hist_shift;
          if (count < CountSat) begin
            count_next = count + count_t'(1);
          end
        end
      end else begin
        hist_next = hist_shift;
        priority if (match.start0) begin
          mode_next  = MODE_KIND0;
          count_next = CountStart;
        end else if (match.start1) begin
          mode_next  = MODE_KIND1;
          count_next = CountStart;
        end else begin
          mode_next = MODE_HUNT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= '0;
      mode  <= MODE_HUNT;
      count <= '0;
    end else begin
      hist  <= hist_next;
      mode  <= mode_next;
      count <= count_next;
    end
  end

  dpf_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .single_word  (data_word),
    .burst_words  (burst_t'(hist_shift[HistDepth-1:WinBase])),
    .stall        (out_stall),
    .out_valid    (out_valid),
    .out_word     (out_word),
    .packet_first (packet_first),
    .packet_last  (packet_last),
    .packet_kind  (packet_kind),
    .burst_last   (burst_last),
    .free         (free)
  );

  // A header match opens a burst whose first word appears next cycle.
  a_start_burst : assert property (@(posedge clk) disable iff (rst)
    in_acc && !in_pkt && start_hit |=> out_valid && packet_first && !burst_last)
    else $error("header match did not open a burst");

  // A trailer returns the framer to hunting with a cleared history.
  a_end_clears : assert property (@(posedge clk) disable iff (rst)
    in_acc && in_pkt && end_hit |=> mode == MODE_HUNT && hist == '0 &&
    out_valid && packet_last)
    else $error("trailer did not close the packet");

  // Input is only taken when the queue holds at most its final word.
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid || burst_last)
    else $error("input taken while a burst is still draining");

endmodule

`default_nettype wire

[rtl/core/dpf_match.sv]
// ----------------------------------------------------------------------------
// dpf_match
// Header and trailer pattern detection on the shifted word history.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_match import dpf_pkg::*; (
  input  hist_t  hist,
  input  count_t count,
  output match_t match
);

  always_comb begin
    match.start0 = (hist[9] == WORD_8000) && (hist[10] == WORD_0001) &&
                   (hist[11] == WORD_8000);
    match.start1 = (hist[4][15:12] == NIB_9) && (hist[5][15:12] == NIB_9) &&
                   (hist[6][15:12] == NIB_9) && (hist[7][15:12] == NIB_9) &&
                   (hist[8][15:12] == NIB_A) && (hist[9][15:12] == NIB_A) &&
                   (hist[10][15:12] == NIB_A);
    // The count is the index of the current word within its packet, saturating at 20.
    match.end0   = (count >= EndMinCount) &&
                   (hist[0] == WORD_8000) && (hist[1] == WORD_8000) &&
                   (hist[2] == WORD_FFFF) && (hist[3] == WORD_8000);
    match.end1   = (hist[4][15:12] == NIB_F) && (hist[5][15:12] == NIB_F) &&
                   (hist[6][15:12] == NIB_F) && (hist[7][15:12] == NIB_F) &&
                   (hist[8][15:12] == NIB_E) && (hist[9][15:12] == NIB_E) &&
                   (hist[10][15:12] == NIB_E);
  end

endmodule

`default_nettype wire

[rtl/core/dpf_outq.sv]
// ----------------------------------------------------------------------------
// dpf_outq
// Result register with an eight-word burst buffer that drains one word per
// transaction on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_outq import dpf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  load_t  load,
  input  word_t  single_word,
  input  burst_t burst_words,
  input  logic   stall,
  output logic   out_valid,
  output word_t  out_word,
  output logic   packet_first,
  output logic   packet_last,
  output logic   packet_kind,
  output logic   burst_last,
  output logic   free
);

  burst_t buffer;
  rem_t   rem;
  rem_t   rem_next;
  logic   is_burst;
  logic   last;
  logic   kind;
  logic   out_acc;

  assign out_valid    = (rem != '0);
  assign out_acc      = out_valid && !stall;
  // Room for a new input when the queue is empty or drains its final word now.
  assign free         = (rem == '0) || ((rem == rem_t'(1)) && !stall);
  assign out_word     = buffer[0];
  assign packet_first = is_burst && (rem == BurstRem);
  assign packet_last  = last;
  assign packet_kind  = kind;
  assign burst_last   = (rem == rem_t'(1));

  always_comb begin
    rem_next = rem;
    if (out_acc) begin
      rem_next = rem - rem_t'(1);
    end
    if (load.valid) begin
      rem_next = load.burst ? BurstRem : rem_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem      <= '0;
      is_burst <= 1'b0;
      last     <= 1'b0;
      kind     <= 1'b0;
    end else begin
      rem <= rem_next;
      if (load.valid) begin
        is_burst <= load.burst;
        last     <= load.last;
        kind     <= load.kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      if (load.burst) begin
        buffer <= burst_words;
      end else begin
        buffer[0] <= single_word;
      end
    end else if (out_acc) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        buffer[i] <= buffer[i+1];
      end
    end
  end

endmodule

`default_nettype wire
